// ----- rtl/core/tabular_q_learning_engine_core_macros.svh -----
// ----------------------------------------------------------------------------
// tabular q-learning engine core assertion macros
// assertion wrappers shared by the core rtl, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef TABULAR_Q_LEARNING_ENGINE_CORE_MACROS_SVH
`define TABULAR_Q_LEARNING_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define TQLE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TQLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TQLE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define TQLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/core/tqle_pkg.sv -----
// ----------------------------------------------------------------------------
// tqle_pkg
// shared types, codes and defaults of the tabular q-learning engine core
// ----------------------------------------------------------------------------
package tqle_pkg;

   localparam int MAX_STATES_DEF  = 256;
   localparam int MAX_ACTIONS_DEF = 8;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int MODE_W     = 2;
   localparam int STATE_W    = 8;
   localparam int ACTION_W   = 3;
   localparam int REWARD_W   = 32;
   localparam int FRAC_W     = 16;
   localparam int FRAC_DIGIT_W = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CFG_STATES_W  = 9;
   localparam int CFG_ACTIONS_W = 4;

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CHOOSE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_STATES  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_ACTIONS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TERMINAL    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_EPSILON     = 3'd5;

   localparam logic [CFG_STATES_W-1:0]  RST_NUM_STATES  = 9'd256;
   localparam logic [CFG_ACTIONS_W-1:0] RST_NUM_ACTIONS = 4'd8;
   localparam logic [STATE_W-1:0]       RST_TERMINAL    = 8'd0;
   localparam logic [FRAC_W-1:0]        RST_GAMMA       = 16'd58982;
   localparam logic [FRAC_W-1:0]        RST_ALPHA       = 16'd6554;
   localparam logic [FRAC_W-1:0]        RST_EPSILON     = 16'd6554;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [STATE_W-1:0]         current_state;
      logic [ACTION_W-1:0]        taken_action;
      logic signed [REWARD_W-1:0] reward;
      logic [STATE_W-1:0]         next_state;
      logic [FRAC_W-1:0]          explore_draw;
      logic [FRAC_W-1:0]          action_draw;
   } req_type;

   typedef struct packed {
      logic [ACTION_W-1:0] chosen_action;
      logic                was_exploration;
      logic                episode_done;
      logic                index_error;
   } rsp_type;

endpackage

// ----- rtl/core/tqle_qmem.sv -----
// ----------------------------------------------------------------------------
// tqle_qmem
// q table storage, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module tqle_qmem #(
   parameter int DEPTH = tqle_pkg::MAX_STATES_DEF * tqle_pkg::MAX_ACTIONS_DEF,
   parameter int WIDTH = tqle_pkg::VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/tqle_fmul.sv -----
// ----------------------------------------------------------------------------
// tqle_fmul
// signed value times unsigned q0.16 fraction, floored, one digit per cycle
// ----------------------------------------------------------------------------
module tqle_fmul #(
   parameter int WIDTH = tqle_pkg::VALUE_WIDTH_DEF + 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [WIDTH-1:0]          operand,
   input  logic [tqle_pkg::FRAC_W-1:0]      frac,
   output logic                             done,
   output logic signed [WIDTH-1:0]          result
);

   localparam int FW     = tqle_pkg::FRAC_W;
   localparam int DW     = tqle_pkg::FRAC_DIGIT_W;
   localparam int NDIG   = FW / DW;
   localparam int CNT_W  = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int ACC_W  = WIDTH + FW + 1;

   logic                    run_ff;
   logic                    done_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic signed [WIDTH-1:0] op_ff;
   logic [FW-1:0]           frac_ff;
   logic signed [ACC_W-1:0] acc_ff;

   logic [DW-1:0]             digit;
   logic signed [WIDTH+DW:0]  partial;
   logic signed [ACC_W-1:0]   acc_in;

   always_comb begin
      digit   = frac_ff[FW-1 -: DW];
      partial = op_ff * $signed({1'b0, digit});
      acc_in  = (acc_ff <<< DW) + ACC_W'(partial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NDIG - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff   <= operand;
         frac_ff <= frac;
         acc_ff  <= '0;
      end else if (run_ff) begin
         acc_ff  <= acc_in;
         frac_ff <= frac_ff << DW;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff[WIDTH+FW-1:FW];

endmodule

// ----- rtl/core/tabular_q_learning_engine_core.sv -----
// ----------------------------------------------------------------------------
// tabular_q_learning_engine_core
// q table with epsilon-greedy action choice and q-learning update
//
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    tqle_pkg::req_type
// rsp       out        rsp_valid/rsp_ready    tqle_pkg::rsp_type
// csr       in         csr_wr_en              csr_index, csr_wdata
//
// choose: a scan of the state's row, skipped when exploring or flagged
// update: unless flagged, a next-state row scan through the single table
//   read port, two fraction multiplies, a rescan unless exploring or done
// clear and reset: one table entry per cycle over all MAX_STATES*MAX_ACTIONS
//   entries, no transaction accepted meanwhile
// a finished result waits in the output register while the next is taken
// ----------------------------------------------------------------------------
`include "tabular_q_learning_engine_core_macros.svh"

module tabular_q_learning_engine_core #(
   parameter int MAX_STATES  = tqle_pkg::MAX_STATES_DEF,
   parameter int MAX_ACTIONS = tqle_pkg::MAX_ACTIONS_DEF,
   parameter int VALUE_WIDTH = tqle_pkg::VALUE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tqle_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tqle_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [tqle_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tqle_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DEPTH  = MAX_STATES * MAX_ACTIONS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int AIDX_W = $clog2(MAX_ACTIONS);
   localparam int VW     = VALUE_WIDTH;
   localparam int TW     = (VW + 2 > 64) ? 64 : VW + 2;
   localparam int RX_W   = (VW > tqle_pkg::REWARD_W) ? VW : tqle_pkg::REWARD_W;
   localparam int FW     = tqle_pkg::FRAC_W;
   localparam int NSW    = tqle_pkg::CFG_STATES_W;
   localparam int NAW    = tqle_pkg::CFG_ACTIONS_W;
   localparam int SW     = tqle_pkg::STATE_W;
   localparam int AW     = tqle_pkg::ACTION_W;

   localparam logic signed [TW:0] T_HI = {2'b00, {(TW-1){1'b1}}};
   localparam logic signed [TW:0] T_LO = {2'b11, {(TW-1){1'b0}}};
   localparam logic signed [TW:0] V_HI = {{(TW+2-VW){1'b0}}, {(VW-1){1'b1}}};
   localparam logic signed [TW:0] V_LO = {{(TW+2-VW){1'b1}}, {(VW-1){1'b0}}};
   localparam logic signed [RX_W-1:0] R_HI = {{(RX_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
   localparam logic signed [RX_W-1:0] R_LO = {{(RX_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

   typedef enum logic [8:0] {
      S_CLEAR     = 9'b000000001,
      S_IDLE      = 9'b000000010,
      S_SCAN      = 9'b000000100,
      S_SCAN_LAST = 9'b000001000,
      S_MULG      = 9'b000010000,
      S_WAITG     = 9'b000100000,
      S_TD        = 9'b001000000,
      S_WAITA     = 9'b010000000,
      S_RESP      = 9'b100000000
   } state_type;

   function automatic logic signed [TW-1:0] sat_tw(input logic signed [TW:0] v);
      logic signed [TW-1:0] r;
      if (v > T_HI) begin
         r = T_HI[TW-1:0];
      end else if (v < T_LO) begin
         r = T_LO[TW-1:0];
      end else begin
         r = v[TW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [VW-1:0] sat_vw(input logic signed [TW:0] v);
      logic signed [VW-1:0] r;
      if (v > V_HI) begin
         r = V_HI[VW-1:0];
      end else if (v < V_LO) begin
         r = V_LO[VW-1:0];
      end else begin
         r = v[VW-1:0];
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] pick_random(input logic [FW-1:0] d,
                                                 input logic [NAW-1:0] n);
      logic [FW+NAW-1:0] p;
      p = (FW+NAW)'(d) * (FW+NAW)'(n);
      return AW'(p[FW+NAW-1:FW]);
   endfunction

   // configuration
   logic [NSW-1:0] cfg_states_ff;
   logic [NAW-1:0] cfg_actions_ff;
   logic [SW-1:0]  cfg_terminal_ff;
   logic [FW-1:0]  cfg_gamma_ff;
   logic [FW-1:0]  cfg_alpha_ff;
   logic [FW-1:0]  cfg_epsilon_ff;

   logic [NAW-1:0]    na_eff;
   logic [AIDX_W-1:0] na_last;
   logic [NSW-1:0]    ns_last;

   // sequencer
   state_type            state_ff, state_in;
   tqle_pkg::req_type    req_ff, req_in;
   logic [ADDR_W-1:0]    row_ff, row_in;
   logic [ADDR_W-1:0]    qaddr_ff, qaddr_in;
   logic                 scan_max_ff, scan_max_in;
   logic [AIDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [AIDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic signed [VW-1:0] best_ff, best_in;
   logic [AIDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic                 clr_resp_ff, clr_resp_in;
   logic signed [VW-1:0] q_ff, q_in;
   logic signed [TW-1:0] target_ff, target_in;
   tqle_pkg::rsp_type    res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tqle_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   // memory and multiplier hookup
   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [VW-1:0]        mem_wr_data;
   logic                 mem_rd_en;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [VW-1:0]        mem_rd_data;
   logic signed [VW-1:0] q_rd;

   logic                 fm_start;
   logic signed [TW-1:0] fm_op;
   logic [FW-1:0]        fm_frac;
   logic                 fm_done;
   logic signed [TW-1:0] fm_res;

   // arithmetic
   logic signed [RX_W-1:0] r_wide;
   logic signed [VW-1:0]   r_vw;
   logic signed [TW-1:0]   r_tw;
   logic signed [TW-1:0]   q_tw;
   logic signed [TW:0]     tgt_sum;
   logic signed [TW:0]     td_sum;
   logic signed [TW:0]     nq_sum;
   logic signed [TW-1:0]   td_val;
   logic signed [VW-1:0]   nq_val;

   // request decode
   logic              s_bad;
   logic              s2_bad;
   logic              a_bad;
   logic              explore_req;
   logic              explore_held;
   logic [ADDR_W-1:0] row_s;
   logic [ADDR_W-1:0] row_s2;

   tqle_qmem #(
      .DEPTH (DEPTH),
      .WIDTH (VW)
   ) u_qmem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   tqle_fmul #(
      .WIDTH (TW)
   ) u_fmul (
      .clock   (clock),
      .reset   (reset),
      .start   (fm_start),
      .operand (fm_op),
      .frac    (fm_frac),
      .done    (fm_done),
      .result  (fm_res)
   );

   assign q_rd = signed'(mem_rd_data);

   always_comb begin
      if (cfg_actions_ff == '0) begin
         na_eff = NAW'(1);
      end else if (int'(cfg_actions_ff) > MAX_ACTIONS) begin
         na_eff = NAW'(MAX_ACTIONS);
      end else begin
         na_eff = cfg_actions_ff;
      end
      na_last = AIDX_W'(na_eff - NAW'(1));
      if (cfg_states_ff == '0) begin
         ns_last = '0;
      end else if (int'(cfg_states_ff) > MAX_STATES) begin
         ns_last = NSW'(MAX_STATES - 1);
      end else begin
         ns_last = cfg_states_ff - NSW'(1);
      end
   end

   always_comb begin
      s_bad        = NSW'(req_data.current_state) > ns_last;
      s2_bad       = NSW'(req_data.next_state) > ns_last;
      a_bad        = NAW'(req_data.taken_action) >= na_eff;
      explore_req  = req_data.explore_draw < cfg_epsilon_ff;
      explore_held = req_ff.explore_draw < cfg_epsilon_ff;
      row_s        = ADDR_W'(int'(req_data.current_state) * MAX_ACTIONS);
      row_s2       = ADDR_W'(int'(req_data.next_state) * MAX_ACTIONS);
   end

   always_comb begin
      r_wide = RX_W'(req_ff.reward);
      if (r_wide > R_HI) begin
         r_vw = R_HI[VW-1:0];
      end else if (r_wide < R_LO) begin
         r_vw = R_LO[VW-1:0];
      end else begin
         r_vw = r_wide[VW-1:0];
      end
      r_tw    = TW'(r_vw);
      q_tw    = TW'(q_ff);
      tgt_sum = (TW+1)'(r_tw) + (TW+1)'(fm_res);
      td_sum  = (TW+1)'(target_ff) - (TW+1)'(q_tw);
      nq_sum  = (TW+1)'(q_tw) + (TW+1)'(fm_res);
      td_val  = sat_tw(td_sum);
      nq_val  = sat_vw(nq_sum);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      row_in       = row_ff;
      qaddr_in     = qaddr_ff;
      scan_max_in  = scan_max_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = scan_idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      clr_addr_in  = clr_addr_ff;
      clr_resp_in  = clr_resp_ff;
      q_in         = q_ff;
      target_in    = target_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = row_ff + ADDR_W'(scan_idx_ff);
      fm_start    = 1'b0;
      fm_op       = TW'(best_ff);
      fm_frac     = cfg_gamma_ff;

      // running max with lowest index on ties
      if (cmp_vld_ff && ((cmp_idx_ff == '0) || (q_rd > best_ff))) begin
         best_in     = q_rd;
         best_idx_in = cmp_idx_ff;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               clr_addr_in = '0;
               res_in      = '0;
               state_in    = clr_resp_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               res_in      = '0;
               scan_idx_in = '0;
               qaddr_in    = row_s + ADDR_W'(req_data.taken_action);
               case (req_data.mode)
                  tqle_pkg::MODE_CLEAR: begin
                     clr_resp_in = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  tqle_pkg::MODE_CHOOSE: begin
                     row_in      = row_s;
                     scan_max_in = 1'b0;
                     if (s_bad) begin
                        res_in.index_error = 1'b1;
                        state_in           = S_RESP;
                     end else if (explore_req) begin
                        res_in.chosen_action   = pick_random(req_data.action_draw, na_eff);
                        res_in.was_exploration = 1'b1;
                        state_in               = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  tqle_pkg::MODE_UPDATE: begin
                     row_in      = row_s2;
                     scan_max_in = 1'b1;
                     if (s_bad || a_bad || s2_bad) begin
                        res_in.index_error = 1'b1;
                        state_in           = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            mem_rd_en   = 1'b1;
            cmp_vld_in  = 1'b1;
            scan_idx_in = scan_idx_ff + 1'b1;
            if (scan_idx_ff == na_last) begin
               state_in = S_SCAN_LAST;
            end
         end
         S_SCAN_LAST: begin
            if (scan_max_ff) begin
               state_in = S_MULG;
            end else begin
               res_in.chosen_action = AW'(best_idx_in);
               state_in             = S_RESP;
            end
         end
         S_MULG: begin
            fm_start    = 1'b1;
            mem_rd_en   = 1'b1;
            mem_rd_addr = qaddr_ff;
            state_in    = S_WAITG;
         end
         S_WAITG: begin
            q_in = q_rd;
            if (fm_done) begin
               target_in = sat_tw(tgt_sum);
               state_in  = S_TD;
            end
         end
         S_TD: begin
            fm_start = 1'b1;
            fm_op    = td_val;
            fm_frac  = cfg_alpha_ff;
            state_in = S_WAITA;
         end
         S_WAITA: begin
            if (fm_done) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = qaddr_ff;
               mem_wr_data = nq_val;
               scan_idx_in = '0;
               scan_max_in = 1'b0;
               if (req_ff.next_state == cfg_terminal_ff) begin
                  res_in.episode_done = 1'b1;
                  state_in            = S_RESP;
               end else if (explore_held) begin
                  res_in.chosen_action   = pick_random(req_ff.action_draw, na_eff);
                  res_in.was_exploration = 1'b1;
                  state_in               = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_addr_ff     <= '0;
         clr_resp_ff     <= 1'b0;
         scan_idx_ff     <= '0;
         cmp_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         cfg_states_ff   <= tqle_pkg::RST_NUM_STATES;
         cfg_actions_ff  <= tqle_pkg::RST_NUM_ACTIONS;
         cfg_terminal_ff <= tqle_pkg::RST_TERMINAL;
         cfg_gamma_ff    <= tqle_pkg::RST_GAMMA;
         cfg_alpha_ff    <= tqle_pkg::RST_ALPHA;
         cfg_epsilon_ff  <= tqle_pkg::RST_EPSILON;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_resp_ff  <= clr_resp_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               tqle_pkg::CSR_NUM_STATES:  cfg_states_ff   <= csr_wdata[NSW-1:0];
               tqle_pkg::CSR_NUM_ACTIONS: cfg_actions_ff  <= csr_wdata[NAW-1:0];
               tqle_pkg::CSR_TERMINAL:    cfg_terminal_ff <= csr_wdata[SW-1:0];
               tqle_pkg::CSR_GAMMA:       cfg_gamma_ff    <= csr_wdata[FW-1:0];
               tqle_pkg::CSR_ALPHA:       cfg_alpha_ff    <= csr_wdata[FW-1:0];
               tqle_pkg::CSR_EPSILON:     cfg_epsilon_ff  <= csr_wdata[FW-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      row_ff      <= row_in;
      qaddr_ff    <= qaddr_in;
      scan_max_ff <= scan_max_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      q_ff        <= q_in;
      target_ff   <= target_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TQLE_ASSERT_IMPLY(a_fmul_done_in_wait, clock, reset, fm_done, (state_ff == S_WAITG) || (state_ff == S_WAITA), "multiplier finished outside a wait state")
   `TQLE_ASSERT_IMPLY(a_scan_within_row, clock, reset, state_ff == S_SCAN, scan_idx_ff <= na_last, "row scan ran past the last action in use")
   `TQLE_ASSERT_IMPLY(a_done_has_no_action, clock, reset, rsp_valid_ff && rsp_data_ff.episode_done, (rsp_data_ff.chosen_action == '0) && !rsp_data_ff.was_exploration && !rsp_data_ff.index_error, "episode end carries an action")
   `TQLE_ASSERT_NEXT(a_result_loaded, clock, reset, (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == S_IDLE), "result not loaded into output register")

endmodule

// ----- verif/tabular_q_learning_engine_core_test.sv -----
// ----------------------------------------------------------------------------
// tabular_q_learning_engine_core_test
// Drives requests through the q-learning core and predicts every response
// from a private copy of the q table and the settings. A short script covers
// reset values, field extremes, every mode, out-of-range indexes, the
// terminal state and saturation. Random phases under several settings follow,
// with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tabular_q_learning_engine_core_test;
   import tqle_pkg::*;

   localparam int STATES_MAX    = MAX_STATES_DEF;
   localparam int ACTIONS_MAX   = MAX_ACTIONS_DEF;
   localparam int VALUE_BITS    = VALUE_WIDTH_DEF;
   localparam int TD_BITS       = (VALUE_BITS + 2 > 64) ? 64 : VALUE_BITS + 2;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_TXNS    = 125;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   localparam rsp_type NOTHING      = '0;
   localparam rsp_type FLAGGED      = '{3'd0, 1'b0, 1'b0, 1'b1};
   localparam rsp_type DONE         = '{3'd0, 1'b0, 1'b1, 1'b0};
   localparam rsp_type EXPLORED_TOP = '{3'd7, 1'b1, 1'b0, 1'b0};
   localparam rsp_type EXPLORED_LOW = '{3'd0, 1'b1, 1'b0, 1'b0};

   typedef struct {
      bit                     cfg_write;
      logic [CSR_INDEX_W-1:0] csr_sel;
      logic [CSR_DATA_W-1:0]  csr_val;
      req_type                txn;
      bit                     typed;
      rsp_type                want;
   } script_row_t;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   longint              q_model [STATES_MAX*ACTIONS_MAX];
   logic [8:0]          cfg_states   = RST_NUM_STATES;
   logic [3:0]          cfg_actions  = RST_NUM_ACTIONS;
   logic [7:0]          cfg_terminal = RST_TERMINAL;
   logic [15:0]         cfg_gamma    = RST_GAMMA;
   logic [15:0]         cfg_alpha    = RST_ALPHA;
   logic [15:0]         cfg_epsilon  = RST_EPSILON;

   rsp_type             queued_choices [$];
   script_row_t         script [$];
   int                  fault_count = 0;
   int                  burst_left  = 0;
   logic [10:0]         stall_clock = '0;
   int                  hold_left   = 0;

   tabular_q_learning_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic int states_in_use();
      if (cfg_states == 0) return 1;
      if (cfg_states > STATES_MAX) return STATES_MAX;
      return int'(cfg_states);
   endfunction

   function automatic int actions_in_use();
      if (cfg_actions == 0) return 1;
      if (cfg_actions > ACTIONS_MAX) return ACTIONS_MAX;
      return int'(cfg_actions);
   endfunction

   function automatic longint clamp_bits(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // floor of v times a q0.16 fraction
   function automatic longint scale_frac(longint v, int f);
      longint p;
      p = v * longint'(f);
      return p >>> 16;
   endfunction

   function automatic longint row_best(int s, int na);
      longint best;
      best = q_model[s*ACTIONS_MAX];
      for (int a = 1; a < na; a++)
         if (q_model[s*ACTIONS_MAX + a] > best) best = q_model[s*ACTIONS_MAX + a];
      return best;
   endfunction

   function automatic int epsilon_greedy(int s, int na, int ed, int ad, output bit explored);
      int     best;
      longint bv;
      if (ed < int'(cfg_epsilon)) begin
         explored = 1'b1;
         return (ad * na) >> 16;
      end
      explored = 1'b0;
      best = 0;
      bv = q_model[s*ACTIONS_MAX];
      for (int a = 1; a < na; a++) begin
         if (q_model[s*ACTIONS_MAX + a] > bv) begin
            bv = q_model[s*ACTIONS_MAX + a];
            best = a;
         end
      end
      return best;
   endfunction

   function automatic rsp_type learn_and_choose(req_type t);
      rsp_type r;
      int      ns, na, s, a, s2, act;
      bit      expl;
      longint  rw, q, target, td;
      r  = '0;
      ns = states_in_use();
      na = actions_in_use();
      s  = int'(t.current_state);
      a  = int'(t.taken_action);
      s2 = int'(t.next_state);
      case (t.mode)
         MODE_CLEAR: begin
            foreach (q_model[i]) q_model[i] = 0;
         end
         MODE_CHOOSE: begin
            if (s >= ns) begin
               r.index_error = 1'b1;
            end else begin
               act = epsilon_greedy(s, na, int'(t.explore_draw), int'(t.action_draw), expl);
               r.chosen_action   = 3'(act);
               r.was_exploration = expl;
            end
         end
         MODE_UPDATE: begin
            if (s >= ns || a >= na || s2 >= ns) begin
               r.index_error = 1'b1;
            end else begin
               rw     = clamp_bits(longint'($signed(t.reward)), VALUE_BITS);
               q      = q_model[s*ACTIONS_MAX + a];
               target = clamp_bits(rw + scale_frac(row_best(s2, na), int'(cfg_gamma)), TD_BITS);
               td     = clamp_bits(target - q, TD_BITS);
               q_model[s*ACTIONS_MAX + a] =
                  clamp_bits(q + scale_frac(td, int'(cfg_alpha)), VALUE_BITS);
               if (t.next_state == cfg_terminal) begin
                  r.episode_done = 1'b1;
               end else begin
                  act = epsilon_greedy(s2, na, int'(t.explore_draw), int'(t.action_draw), expl);
                  r.chosen_action   = 3'(act);
                  r.was_exploration = expl;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic script_row_t cfg_row(logic [CSR_INDEX_W-1:0] sel, int value);
      script_row_t row;
      row = '{default: '0};
      row.cfg_write = 1'b1;
      row.csr_sel   = sel;
      row.csr_val   = 16'(value);
      return row;
   endfunction

   function automatic script_row_t txn_row(logic [MODE_W-1:0] m, int s, int a, int rw, int s2,
                                           int ed, int ad, bit typed, rsp_type want);
      script_row_t row;
      row = '{default: '0};
      row.txn.mode          = m;
      row.txn.current_state = 8'(s);
      row.txn.taken_action  = 3'(a);
      row.txn.reward        = rw;
      row.txn.next_state    = 8'(s2);
      row.txn.explore_draw  = 16'(ed);
      row.txn.action_draw   = 16'(ad);
      row.typed             = typed;
      row.want              = want;
      return row;
   endfunction

   function automatic req_type random_txn();
      req_type t;
      int      ns, na, pick;
      ns   = states_in_use();
      na   = actions_in_use();
      pick = $urandom_range(0, 99);
      if (pick < 3)       t.mode = MODE_CLEAR;
      else if (pick < 6)  t.mode = MODE_UNUSED;
      else if (pick < 40) t.mode = MODE_CHOOSE;
      else                t.mode = MODE_UPDATE;
      t.current_state = ($urandom_range(0, 11) == 0) ? 8'($urandom) : 8'($urandom_range(0, ns-1));
      t.taken_action  = ($urandom_range(0, 11) == 0) ? 3'($urandom) : 3'($urandom_range(0, na-1));
      pick = $urandom_range(0, 19);
      if (pick < 3)       t.next_state = cfg_terminal;
      else if (pick == 3) t.next_state = 8'($urandom);
      else                t.next_state = 8'($urandom_range(0, ns-1));
      case ($urandom_range(0, 9))
         0:       t.reward = 32'sh7FFFFFFF;
         1:       t.reward = 32'sh80000000;
         2, 3:    t.reward = $urandom;
         default: t.reward = 32'($urandom_range(0, 32'h3FFFF) - 32'h20000);
      endcase
      case ($urandom_range(0, 7))
         0:       t.explore_draw = cfg_epsilon;
         1:       t.explore_draw = cfg_epsilon - 16'(cfg_epsilon != 0);
         default: t.explore_draw = 16'($urandom);
      endcase
      t.action_draw = 16'($urandom);
      return t;
   endfunction

   task automatic send_txn(input req_type txn, input bit typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_data  <= txn;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      predicted = learn_and_choose(txn);
      queued_choices.push_back(typed ? want : predicted);
   endtask

   task automatic write_setting(input logic [CSR_INDEX_W-1:0] sel,
                                input logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      burst_left = 0;
      while (queued_choices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (sel)
         CSR_NUM_STATES:  cfg_states   = value[8:0];
         CSR_NUM_ACTIONS: cfg_actions  = value[3:0];
         CSR_TERMINAL:    cfg_terminal = value[7:0];
         CSR_GAMMA:       cfg_gamma    = value;
         CSR_ALPHA:       cfg_alpha    = value;
         CSR_EPSILON:     cfg_epsilon  = value;
         default: ;
      endcase
   endtask

   task automatic set_phase(input int phase);
      int ns;
      case (phase)
         0: begin
            write_setting(CSR_NUM_STATES, 16'd8);
            write_setting(CSR_NUM_ACTIONS, 16'd4);
            write_setting(CSR_TERMINAL, 16'd7);
            write_setting(CSR_GAMMA, RST_GAMMA);
            write_setting(CSR_ALPHA, 16'd32768);
            write_setting(CSR_EPSILON, RST_EPSILON);
         end
         1: begin
            write_setting(CSR_NUM_STATES, 16'd4);
            write_setting(CSR_NUM_ACTIONS, 16'd3);
            write_setting(CSR_TERMINAL, 16'd3);
            write_setting(CSR_GAMMA, 16'hFFFF);
            write_setting(CSR_ALPHA, 16'hFFFF);
            write_setting(CSR_EPSILON, 16'd0);
         end
         2: begin
            write_setting(CSR_NUM_STATES, 16'd256);
            write_setting(CSR_NUM_ACTIONS, 16'd8);
            write_setting(CSR_TERMINAL, 16'd255);
            write_setting(CSR_GAMMA, 16'd0);
            write_setting(CSR_ALPHA, 16'd0);
            write_setting(CSR_EPSILON, 16'hFFFF);
         end
         3: begin
            write_setting(CSR_NUM_STATES, 16'd0);
            write_setting(CSR_NUM_ACTIONS, 16'd0);
            write_setting(CSR_TERMINAL, 16'd0);
            write_setting(CSR_GAMMA, 16'($urandom));
            write_setting(CSR_ALPHA, 16'($urandom));
            write_setting(CSR_EPSILON, 16'($urandom));
         end
         4: begin
            write_setting(CSR_NUM_STATES, 16'd511);
            write_setting(CSR_NUM_ACTIONS, 16'd15);
            write_setting(CSR_TERMINAL, 16'($urandom_range(0, 255)));
            write_setting(CSR_GAMMA, 16'($urandom));
            write_setting(CSR_ALPHA, 16'($urandom));
            write_setting(CSR_EPSILON, 16'($urandom));
         end
         default: begin
            ns = $urandom_range(2, 32);
            write_setting(CSR_NUM_STATES, 16'(ns));
            write_setting(CSR_NUM_ACTIONS, 16'($urandom_range(1, 8)));
            write_setting(CSR_TERMINAL, 16'($urandom_range(0, ns-1)));
            write_setting(CSR_GAMMA, 16'($urandom));
            write_setting(CSR_ALPHA, 16'($urandom));
            write_setting(CSR_EPSILON, 16'($urandom));
         end
      endcase
   endtask

   initial begin : stimulus
      script_row_t row;
      foreach (q_model[i]) q_model[i] = 0;

      // reset settings, empty table
      script.push_back(txn_row(MODE_CHOOSE, 0, 0, 0, 0, 'hFFFF, 'h0000, TYPED, NOTHING));
      script.push_back(txn_row(MODE_CHOOSE, 255, 0, 0, 0, 'h0000, 'hFFFF, TYPED, EXPLORED_TOP));
      script.push_back(txn_row(MODE_CHOOSE, 255, 0, 0, 0, 'h0000, 'h0000, TYPED, EXPLORED_LOW));
      script.push_back(txn_row(MODE_UNUSED, 255, 7, -1, 255, 'hFFFF, 'hFFFF, TYPED, NOTHING));
      script.push_back(txn_row(MODE_UPDATE, 5, 7, 32'h7FFFFFFF, 0, 'hFFFF, 0, TYPED, DONE));
      script.push_back(txn_row(MODE_UPDATE, 5, 0, 32'h80000000, 5, 'hFFFF, 0, PREDICTED, NOTHING));
      script.push_back(txn_row(MODE_CHOOSE, 5, 0, 0, 0, 'hFFFF, 0, PREDICTED, NOTHING));
      script.push_back(txn_row(MODE_UPDATE, 1, 2, 'h10000, 5, 6553, 'h8000, PREDICTED, NOTHING));
      script.push_back(txn_row(MODE_CLEAR, 255, 7, -1, 255, 'hFFFF, 'hFFFF, TYPED, NOTHING));
      script.push_back(txn_row(MODE_CHOOSE, 5, 0, 0, 0, 'hFFFF, 0, TYPED, NOTHING));
      // small table, greedy, full-strength fractions
      script.push_back(cfg_row(CSR_NUM_STATES, 4));
      script.push_back(cfg_row(CSR_NUM_ACTIONS, 3));
      script.push_back(cfg_row(CSR_TERMINAL, 3));
      script.push_back(cfg_row(CSR_GAMMA, 'hFFFF));
      script.push_back(cfg_row(CSR_ALPHA, 'hFFFF));
      script.push_back(cfg_row(CSR_EPSILON, 0));
      script.push_back(txn_row(MODE_CHOOSE, 4, 0, 0, 0, 'hFFFF, 0, TYPED, FLAGGED));
      script.push_back(txn_row(MODE_UPDATE, 0, 3, 1, 1, 'hFFFF, 0, TYPED, FLAGGED));
      script.push_back(txn_row(MODE_UPDATE, 0, 2, 1, 4, 'hFFFF, 0, TYPED, FLAGGED));
      script.push_back(txn_row(MODE_UPDATE, 3, 2, 32'h7FFFFFFF, 3, 0, 0, TYPED, DONE));
      script.push_back(txn_row(MODE_UPDATE, 3, 2, 32'h7FFFFFFF, 3, 0, 0, TYPED, DONE));
      script.push_back(txn_row(MODE_UPDATE, 0, 1, 32'h80000000, 3, 0, 0, TYPED, DONE));
      script.push_back(txn_row(MODE_UPDATE, 0, 1, 32'h80000000, 3, 0, 0, TYPED, DONE));
      script.push_back(txn_row(MODE_CHOOSE, 0, 0, 0, 0, 'hFFFF, 0, PREDICTED, NOTHING));
      script.push_back(txn_row(MODE_CHOOSE, 3, 0, 0, 0, 0, 0, PREDICTED, NOTHING));
      // zero counts behave as one
      script.push_back(cfg_row(CSR_NUM_STATES, 0));
      script.push_back(cfg_row(CSR_NUM_ACTIONS, 0));
      script.push_back(txn_row(MODE_CHOOSE, 1, 0, 0, 0, 'hFFFF, 0, TYPED, FLAGGED));
      script.push_back(txn_row(MODE_UPDATE, 0, 0, 'h12345, 0, 'hFFFF, 0, PREDICTED, NOTHING));
      script.push_back(txn_row(MODE_UPDATE, 0, 1, 0, 0, 'hFFFF, 0, TYPED, FLAGGED));
      // oversized counts clip to the table size
      script.push_back(cfg_row(CSR_NUM_STATES, 511));
      script.push_back(cfg_row(CSR_NUM_ACTIONS, 15));
      script.push_back(cfg_row(CSR_TERMINAL, 255));
      script.push_back(cfg_row(CSR_EPSILON, 'hFFFF));
      script.push_back(txn_row(MODE_UPDATE, 255, 7, 0, 255, 0, 0, TYPED, DONE));
      script.push_back(txn_row(MODE_CHOOSE, 255, 0, 0, 0, 'hFFFE, 'hE000, TYPED, EXPLORED_TOP));
      script.push_back(txn_row(MODE_CHOOSE, 255, 0, 0, 0, 'hFFFF, 'hE000, PREDICTED, NOTHING));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         row = script[i];
         if (row.cfg_write) write_setting(row.csr_sel, row.csr_val);
         else send_txn(row.txn, row.typed, row.want);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_phase(phase);
         for (int n = 0; n < PHASE_TXNS; n++) send_txn(random_txn(), PREDICTED, NOTHING);
      end

      req_valid <= 1'b0;
      while (queued_choices.size() != 0) @(posedge clock);
      repeat (48) @(posedge clock);
      if (fault_count == 0 && queued_choices.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      stall_clock <= stall_clock + 1'b1;
      case (stall_clock[10:9])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 1) == 1);
         2'd2: rsp_ready <= (stall_clock[2:0] == 3'd0);
         default: begin
            if (hold_left == 0) begin
               rsp_ready <= ~rsp_ready;
               hold_left <= $urandom_range(0, 24);
            end else begin
               hold_left <= hold_left - 1;
            end
         end
      endcase
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (queued_choices.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected transaction: act=%0d expl=%0b done=%0b err=%0b",
                        rsp_data.chosen_action, rsp_data.was_exploration,
                        rsp_data.episode_done, rsp_data.index_error);
         end else begin
            want = queued_choices.pop_front();
            if (rsp_data.chosen_action !== want.chosen_action ||
                rsp_data.was_exploration !== want.was_exploration ||
                rsp_data.episode_done !== want.episode_done ||
                rsp_data.index_error !== want.index_error) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch: expected act=%0d expl=%0b done=%0b err=%0b, got act=%0d expl=%0b done=%0b err=%0b",
                           want.chosen_action, want.was_exploration, want.episode_done,
                           want.index_error, rsp_data.chosen_action, rsp_data.was_exploration,
                           rsp_data.episode_done, rsp_data.index_error);
            end
         end
      end
   end

endmodule
